// File: hdl/btndb_pkg.sv
// Shared types and constants for the button debounce and press latch block.
`default_nettype none
package btndb_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int TIME_W      = 32;
  localparam int DEB_W       = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 1'd1;

  localparam logic [DEB_W-1:0] DEBOUNCE_MS_RST = 16'd50;
  localparam logic             ACTIVE_LOW_RST  = 1'b1;

  // Per-word command broadcast to every lane
  typedef struct packed {
    logic              do_update;
    logic              do_take;
    logic              do_init;
    logic [TIME_W-1:0] now_ms;
    logic [DEB_W-1:0]  debounce_ms;
  } lane_cmd_t;

  // What one lane reports for the current word
  typedef struct packed {
    logic stable;
    logic taken;
  } lane_res_t;

endpackage
`default_nettype wire

// File: hdl/btndb_lane.sv
// One button's debounce timer, stable state, arm and pending flags.
`default_nettype none
module btndb_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  btndb_pkg::lane_cmd_t  cmd,
  input  logic                  pressed,
  input  logic                  take,
  output btndb_pkg::lane_res_t  res
);
  import btndb_pkg::*;

  logic              raw_r,     raw_nxt;
  logic              stable_r,  stable_nxt;
  logic              armed_r,   armed_nxt;
  logic              pending_r, pending_nxt;
  logic [TIME_W-1:0] last_r,    last_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              expired;

  assign elapsed = cmd.now_ms - last_r;
  assign expired = elapsed >= {{(TIME_W-DEB_W){1'b0}}, cmd.debounce_ms};

  always_comb begin
    raw_nxt     = raw_r;
    stable_nxt  = stable_r;
    armed_nxt   = armed_r;
    pending_nxt = pending_r;
    last_nxt    = last_r;
    res.taken   = 1'b0;
    if (cmd.do_update) begin
      if (pressed != raw_r) begin
        // raw change: restart the timer
        raw_nxt  = pressed;
        last_nxt = cmd.now_ms;
      end else if (expired && (stable_r != raw_r)) begin
        stable_nxt = raw_r;
        if (raw_r) begin
          if (armed_r) begin
            pending_nxt = 1'b1;
            armed_nxt   = 1'b0;
          end
        end else begin
          armed_nxt = 1'b1;
        end
      end
    end else if (cmd.do_take) begin
      res.taken = pending_r & take;
      if (take) begin
        pending_nxt = 1'b0;
      end
    end else if (cmd.do_init) begin
      raw_nxt     = pressed;
      stable_nxt  = pressed;
      armed_nxt   = ~pressed;
      pending_nxt = 1'b0;
      last_nxt    = cmd.now_ms;
    end
    res.stable = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r     <= 1'b0;
      stable_r  <= 1'b0;
      armed_r   <= 1'b0;
      pending_r <= 1'b0;
      last_r    <= '0;
    end else begin
      raw_r     <= raw_nxt;
      stable_r  <= stable_nxt;
      armed_r   <= armed_nxt;
      pending_r <= pending_nxt;
      last_r    <= last_nxt;
    end
  end

  // a stably pressed button is never armed
  a_pressed_not_armed: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r |-> !armed_r)
    else $error("lane armed while stably pressed");

  // a new pending event comes only with a fresh stable press
  a_pending_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pending_r) |-> $rose(stable_r))
    else $error("pending set without a stable press");

endmodule
`default_nettype wire

// File: hdl/btndb_merge.sv
// Merge lane results into the registered result word.
`default_nettype none
module btndb_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  btndb_pkg::lane_res_t                 res [btndb_pkg::NUM_BUTTONS],
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [btndb_pkg::NUM_BUTTONS-1:0]    out_taken_events,
  output logic [btndb_pkg::NUM_BUTTONS-1:0]    out_btn_down,
  output logic                                 out_any_pressed
);
  import btndb_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [NUM_BUTTONS-1:0] taken_r, stable_r;
  logic                   any_r;
  logic [NUM_BUTTONS-1:0] taken_nxt, stable_nxt;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      taken_nxt[i]  = res[i].taken;
      stable_nxt[i] = res[i].stable;
    end
  end

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      taken_r  <= taken_nxt;
      stable_r <= stable_nxt;
      any_r    <= |stable_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_taken_events = taken_r;
  assign out_btn_down     = stable_r;
  assign out_any_pressed  = any_r;

  a_any_matches: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (any_r == (|stable_r)))
    else $error("any_pressed disagrees with the debounced state");

endmodule
`default_nettype wire

// File: hdl/button_debounce_press_latch_core.sv
// Top level of the four-button debouncer with one-shot press events.
// Each button has its own lane that runs the
// 32-bit wrapping timer compare and the stable/arm/pending update in the cycle
// the word is accepted, and a result register presents the word's result on the
// next cycle. A new word is taken every cycle while the result side keeps up;
// in_stall is raised only while a finished result is held under out_stall.
// Modes: update samples pins against each lane's timer, take reads and clears
// pending flags under take_mask, init loads state from the pins, and the
// unused code leaves state alone. Write configuration only while idle.
`default_nettype none
module button_debounce_press_latch_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [btndb_pkg::MODE_W-1:0]        in_mode,
  input  logic [btndb_pkg::NUM_BUTTONS-1:0]   in_pin_levels,
  input  logic [btndb_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [btndb_pkg::NUM_BUTTONS-1:0]   in_take_mask,
  // result word
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [btndb_pkg::NUM_BUTTONS-1:0]   out_taken_events,
  output logic [btndb_pkg::NUM_BUTTONS-1:0]   out_btn_down,
  output logic                                out_any_pressed,
  // configuration
  input  logic                                cfg_we,
  input  logic [btndb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btndb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import btndb_pkg::*;

  logic [DEB_W-1:0]       debounce_ms_r;
  logic                   active_low_r;
  logic                   accept;
  logic [NUM_BUTTONS-1:0] pressed;
  lane_cmd_t              cmd;
  lane_res_t              res [NUM_BUTTONS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_MS_RST;
      active_low_r  <= ACTIVE_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_MS: debounce_ms_r <= cfg_data[DEB_W-1:0];
        CFG_ACTIVE_LOW:  active_low_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold the input while the result register is full and stalled
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Normalize pin levels to pressed levels
  assign pressed = in_pin_levels ^ {NUM_BUTTONS{active_low_r}};

  // Decode the mode into a command broadcast to every lane
  always_comb begin
    cmd             = '0;
    cmd.now_ms      = in_now_ms;
    cmd.debounce_ms = debounce_ms_r;
    case (in_mode)
      MODE_UPDATE: cmd.do_update = accept;
      MODE_TAKE:   cmd.do_take   = accept;
      MODE_INIT:   cmd.do_init   = accept;
      default: ;
    endcase
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    btndb_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .pressed (pressed[g]),
      .take    (in_take_mask[g]),
      .res     (res[g])
    );
  end

  btndb_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (accept),
    .res              (res),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_taken_events (out_taken_events),
    .out_btn_down     (out_btn_down),
    .out_any_pressed  (out_any_pressed)
  );

endmodule
`default_nettype wire

// File: bench/btndb_press_checker.sv
`timescale 1ns / 1ps
// Checker for the button debouncer: it predicts each result word and compares it with the block's.
module btndb_press_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [btndb_pkg::MODE_W-1:0]      in_mode,
  input  logic [btndb_pkg::NUM_BUTTONS-1:0] in_pin_levels,
  input  logic [btndb_pkg::TIME_W-1:0]      in_now_ms,
  input  logic [btndb_pkg::NUM_BUTTONS-1:0] in_take_mask,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [btndb_pkg::NUM_BUTTONS-1:0] out_taken_events,
  input  logic [btndb_pkg::NUM_BUTTONS-1:0] out_btn_down,
  input  logic                              out_any_pressed,
  input  logic                              cfg_we,
  input  logic [btndb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btndb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                fail_count,
  output int                                words_due
);
  import btndb_pkg::*;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] taken;
    logic [NUM_BUTTONS-1:0] stable;
    logic                   any;
  } press_word_t;

  press_word_t            due_q[$];
  press_word_t            head;
  logic [DEB_W-1:0]       deb_ms;
  logic                   low_active;
  logic [NUM_BUTTONS-1:0] raw_lvl;
  logic [NUM_BUTTONS-1:0] stable_lvl;
  logic [NUM_BUTTONS-1:0] armed;
  logic [NUM_BUTTONS-1:0] pend;
  logic [TIME_W-1:0]      stamp [NUM_BUTTONS];

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Advance the debounce state by one word and queue the result it must give.
  task automatic latch_word(input logic [MODE_W-1:0] mode, input logic [NUM_BUTTONS-1:0] pins,
                            input logic [TIME_W-1:0] now, input logic [NUM_BUTTONS-1:0] mask);
    logic [NUM_BUTTONS-1:0] lvl;
    logic [NUM_BUTTONS-1:0] taken;
    logic [TIME_W-1:0]      held;
    press_word_t            w;
    lvl   = low_active ? ~pins : pins;
    taken = '0;
    case (mode)
      MODE_UPDATE: begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          held = now - stamp[b];
          if (lvl[b] != raw_lvl[b]) begin
            raw_lvl[b] = lvl[b];
            stamp[b]   = now;
          end else if (held >= deb_ms && stable_lvl[b] != raw_lvl[b]) begin
            stable_lvl[b] = raw_lvl[b];
            if (!raw_lvl[b]) begin
              armed[b] = 1'b1;
            end else if (armed[b]) begin
              pend[b]  = 1'b1;
              armed[b] = 1'b0;
            end
          end
        end
      end
      MODE_TAKE: begin
        taken = pend & mask;
        pend  = pend & ~mask;
      end
      MODE_INIT: begin
        raw_lvl    = lvl;
        stable_lvl = lvl;
        armed      = ~lvl;
        pend       = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) stamp[b] = now;
      end
      default: ;
    endcase
    w.taken  = taken;
    w.stable = stable_lvl;
    w.any    = |stable_lvl;
    due_q.push_back(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      deb_ms     = DEBOUNCE_MS_RST;
      low_active = ACTIVE_LOW_RST;
      raw_lvl    = '0;
      stable_lvl = '0;
      armed      = '0;
      pend       = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) stamp[b] = '0;
      due_q.delete();
      words_due <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t ns: result word with none expected, got taken %0h down %0h any %0h",
                   $time, out_taken_events, out_btn_down, out_any_pressed);
          fail_count++;
        end else begin
          head = due_q.pop_front();
          check_field("taken_events", head.taken, out_taken_events);
          check_field("btn_down", head.stable, out_btn_down);
          check_field("any_pressed", head.any, out_any_pressed);
        end
      end
      if (in_valid && !in_stall) latch_word(in_mode, in_pin_levels, in_now_ms, in_take_mask);
      if (cfg_we) begin
        if (cfg_index == CFG_DEBOUNCE_MS) deb_ms = cfg_data[DEB_W-1:0];
        else if (cfg_index == CFG_ACTIVE_LOW) low_active = cfg_data[0];
      end
      words_due <= words_due + int'(in_valid && !in_stall) - int'(out_valid && !out_stall);
    end
  end

endmodule

// File: bench/button_debounce_press_latch_core_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives words and configuration into the debouncer and gives the verdict.
module button_debounce_press_latch_core_tb;
  import btndb_pkg::*;

  // The fourth mode code has no meaning in the block; it must leave state alone.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_WORDS = 140;

  logic                   clk                = 1'b0;
  logic                   rst_n              = 1'b0;
  logic                   in_valid           = 1'b0;
  logic                   in_stall;
  logic [MODE_W-1:0]      in_mode            = MODE_UPDATE;
  logic [NUM_BUTTONS-1:0] in_pin_levels      = '0;
  logic [TIME_W-1:0]      in_now_ms          = '0;
  logic [NUM_BUTTONS-1:0] in_take_mask       = '0;
  logic                   out_valid;
  logic                   out_stall          = 1'b0;
  logic [NUM_BUTTONS-1:0] out_taken_events;
  logic [NUM_BUTTONS-1:0] out_btn_down;
  logic                   out_any_pressed;
  logic                   cfg_we             = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index          = CFG_DEBOUNCE_MS;
  logic [CFG_DATA_W-1:0]  cfg_data           = '0;

  int fail_count;
  int words_due;

  // Idle rates in percent; the receiver's rate is read in its own process, so
  // it only changes by nonblocking assignment.
  int send_gap_pct = 0;
  int recv_gap_pct = 0;

  // A flip of hold_toggle asks the receiver for one long hold-off.
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;
  int   quiet_cycles = 0;

  // Button model for the random part: a running clock and the pins as held.
  logic [TIME_W-1:0]      t_now     = '0;
  logic [NUM_BUTTONS-1:0] pins_held = '1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  button_debounce_press_latch_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_pin_levels    (in_pin_levels),
    .in_now_ms        (in_now_ms),
    .in_take_mask     (in_take_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_taken_events (out_taken_events),
    .out_btn_down     (out_btn_down),
    .out_any_pressed  (out_any_pressed),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  btndb_press_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_pin_levels    (in_pin_levels),
    .in_now_ms        (in_now_ms),
    .in_take_mask     (in_take_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_taken_events (out_taken_events),
    .out_btn_down     (out_btn_down),
    .out_any_pressed  (out_any_pressed),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .words_due        (words_due)
  );

  // Result side: stall at the phase's rate, or hold off for a long stretch when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_gap_pct != 0) && ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("button_debounce_press_latch_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, after a random gap, and hold it until it is accepted.
  // Valid stays high when the next word follows without a gap.
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [NUM_BUTTONS-1:0] pins,
                           input logic [TIME_W-1:0] now, input logic [NUM_BUTTONS-1:0] mask);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_pin_levels <= pins;
    in_now_ms     <= now;
    in_take_mask  <= mask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write both registers back to back; only called while the block is idle.
  task automatic set_config(input logic [DEB_W-1:0] deb, input logic low_act);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE_MS;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_LOW;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, low_act};
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct  = send_pct;
    recv_gap_pct <= recv_pct;
  endtask

  // One random word. Most are updates from a button model whose clock moves
  // forward by steps near the debounce time, with presses, releases and
  // one-sample bounces; the rest are takes, re-inits and pure noise.
  task automatic random_word(input int deb);
    int                     pick;
    logic [NUM_BUTTONS-1:0] bounce;
    pick = $urandom_range(99);
    if (pick < 4) begin
      t_now     = ($urandom_range(3) == 0) ? $urandom : t_now + TIME_W'($urandom_range(1000));
      pins_held = NUM_BUTTONS'($urandom_range(15));
      send_word(MODE_INIT, pins_held, t_now, NUM_BUTTONS'($urandom_range(15)));
    end else if (pick < 16) begin
      send_word(MODE_TAKE, NUM_BUTTONS'($urandom_range(15)), $urandom,
                NUM_BUTTONS'($urandom_range(15)));
    end else if (pick < 22) begin
      send_word(MODE_W'($urandom_range(3)), NUM_BUTTONS'($urandom_range(15)), $urandom,
                NUM_BUTTONS'($urandom_range(15)));
    end else begin
      case ($urandom_range(2))
        0:       t_now += TIME_W'($urandom_range(2));
        1:       t_now += TIME_W'(deb + $urandom_range(2) - 1);
        default: t_now += TIME_W'($urandom_range(2 * deb + 2));
      endcase
      pick = $urandom_range(99);
      if (pick < 15) pins_held ^= 4'b0001 << $urandom_range(NUM_BUTTONS - 1);
      bounce = (pick >= 15 && pick < 25) ? 4'b0001 << $urandom_range(NUM_BUTTONS - 1) : '0;
      send_word(MODE_UPDATE, pins_held ^ bounce, t_now, NUM_BUTTONS'($urandom_range(15)));
    end
  endtask

  initial begin
    int deb;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset configuration: 50 ms, pins active low.
    // Update straight after reset: state is all zero, nothing may move.
    send_word(MODE_UPDATE, 4'hF, 32'd0, 4'h0);
    // Init with every pin released arms every button.
    send_word(MODE_INIT, 4'hF, 32'd100, 4'hF);
    // Press button 0 and hold it one sample short of, then right at, the debounce time.
    send_word(MODE_UPDATE, 4'hE, 32'd110, 4'h0);
    send_word(MODE_UPDATE, 4'hE, 32'd159, 4'h0);
    send_word(MODE_UPDATE, 4'hE, 32'd160, 4'h0);
    // Keep holding: no second event.
    send_word(MODE_UPDATE, 4'hE, 32'd500, 4'h0);
    // Take with an empty mask, then a full one, then again: the event comes once.
    send_word(MODE_TAKE, 4'h0, 32'hFFFF_FFFF, 4'h0);
    send_word(MODE_TAKE, 4'hF, 32'd0, 4'hF);
    send_word(MODE_TAKE, 4'hF, 32'd0, 4'hF);
    // Press the rest with a bounce in between; the timer restarts on each change.
    send_word(MODE_UPDATE, 4'h0, 32'd510, 4'hF);
    send_word(MODE_UPDATE, 4'hF, 32'd520, 4'hF);
    send_word(MODE_UPDATE, 4'h0, 32'd530, 4'hF);
    send_word(MODE_UPDATE, 4'h0, 32'd579, 4'hF);
    send_word(MODE_UPDATE, 4'h0, 32'd580, 4'hF);
    // Unused mode: no change at all.
    send_word(MODE_UNUSED, 4'hF, 32'hFFFF_FFFF, 4'hF);
    // Partial take leaves the other flags pending.
    send_word(MODE_TAKE, 4'h0, 32'd0, 4'h5);
    // Init just below the wrap point with two buttons pressed clears pending.
    send_word(MODE_INIT, 4'h3, 32'hFFFF_FFE0, 4'h0);
    send_word(MODE_TAKE, 4'h0, 32'd0, 4'hF);
    // Release across the timestamp wrap: 49 ms, then 50 ms.
    send_word(MODE_UPDATE, 4'hF, 32'hFFFF_FFF0, 4'h0);
    send_word(MODE_UPDATE, 4'hF, 32'h0000_0021, 4'h0);
    send_word(MODE_UPDATE, 4'hF, 32'h0000_0022, 4'h0);
    // Press everything, then a sample far away in wrapped time.
    send_word(MODE_UPDATE, 4'h0, 32'h0000_0030, 4'h0);
    send_word(MODE_UPDATE, 4'h0, 32'hFFFF_FFFF, 4'h0);
    send_word(MODE_TAKE, 4'h0, 32'd0, 4'hF);
    drain();

    // Random phases, each with its own configuration and idling pattern.
    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: begin
          deb = 0;
          set_idling(0, 0);
          set_config(16'd0, 1'b0);
        end
        2: begin
          deb = 65535;
          set_idling(51, 0);
          set_config(16'hFFFF, 1'b1);
        end
        3: begin
          deb = $urandom_range(20, 1);
          set_idling(0, 51);
          set_config(deb[DEB_W-1:0], 1'b0);
        end
        4: begin
          deb = 1;
          set_idling(19, 19);
          set_config(16'd1, 1'b1);
        end
        default: begin
          deb = $urandom_range(100, 2);
          set_idling(0, 0);
          set_config(deb[DEB_W-1:0], $urandom_range(1));
        end
      endcase
      for (int i = 0; i < RANDOM_WORDS; i++) begin
        // Last phase: block the result side while words keep coming, and
        // later pause the sender until everything has come back.
        if (p == 5 && i == 40) hold_toggle <= ~hold_toggle;
        if (p == 5 && i == 90) drain();
        random_word(deb);
      end
      drain();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("button_debounce_press_latch_core_tb OK");
    end else begin
      $display("button_debounce_press_latch_core_tb NOT OK");
    end
    $finish;
  end

endmodule
